### rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg: shared types and constants for the cir short rate stepper
// payload structs, serial multiplier request and fixed-point widths
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int RATE_W     = 32;  // unsigned Q8.24
  localparam int FRAC_W     = 24;
  localparam int NOISE_W    = 16;  // signed Q4.12
  localparam int NOISE_FRAC = 12;
  localparam int IDX_W      = 16;
  localparam int STEP_W     = 25;  // unsigned Q1.24
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // serial multiplier operand widths
  localparam int MCAND_W = 37;
  localparam int MPLR_W  = 32;
  localparam int PROD_W  = 64;

  // square root of rate << 24
  localparam int ROOT_W     = 28;
  localparam int ROOT_STEPS = 28;
  localparam int ROOT_CNT_W = 5;

  // term and sum widths
  localparam int DRIFT_W = 40;
  localparam int DIFF_W  = 41;
  localparam int SUM_W   = 44;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic                      restart;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [IDX_W-1:0]  step_index;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [MPLR_W-1:0]  mplr;
  } mul_req_t;

endpackage

### rtl/cir_sermul.sv
// ----------------------------------------------------------------------------
// cir_sermul: bit-serial shift-add multiplier
// consumes one multiplier bit per cycle, stops once no set bits remain
// ----------------------------------------------------------------------------
module cir_sermul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cir_pkg::mul_req_t            req,
  output logic                         busy,
  output logic [cir_pkg::PROD_W-1:0]   prod
);
  import cir_pkg::*;

  logic              busy_r;
  logic [PROD_W-1:0] mc_r;
  logic [MPLR_W-1:0] mp_r;
  logic [PROD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      mc_r   <= {{(PROD_W-MCAND_W){1'b0}}, req.mcand};
      mp_r   <= req.mplr;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (mp_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r <= {mc_r[PROD_W-2:0], 1'b0};
        mp_r <= {1'b0, mp_r[MPLR_W-1:1]};
      end
    end
  end

  assign busy = busy_r | req.start;
  assign prod = acc_r;

endmodule

### rtl/cir_isqrt.sv
// ----------------------------------------------------------------------------
// cir_isqrt: digit-by-digit integer square root of rate << 24
// two radicand bits in, one root bit out per cycle
// ----------------------------------------------------------------------------
module cir_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cir_pkg::RATE_W-1:0]   rad,
  output logic                         busy,
  output logic [cir_pkg::ROOT_W-1:0]   root
);
  import cir_pkg::*;

  localparam int REM_W = ROOT_W + 1;

  logic                  busy_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic [RATE_W-1:0]     rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_sub;
  logic             fits;

  // low 24 radicand bits are zero: they shift in behind the rate
  always_comb begin
    rem_sh  = {rem_r, rad_r[RATE_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    fits    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ROOT_CNT_W'(ROOT_STEPS);
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RATE_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_sub[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ROOT_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r | start;
  assign root = root_r;

endmodule

### rtl/cir_short_rate_euler_step_top.sv
// ----------------------------------------------------------------------------
// cir_short_rate_euler_step_top: cox-ingersoll-ross euler step, full truncation
// one noise sample in, one new short rate and step index out
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready / in_data): one transfer carries a
//   q4.12 normal sample and a restart flag; restart, or the first transfer
//   after reset, reloads start_rate and zeroes the step index first
//   output channel (out_valid / out_ready / out_data): one transfer per
//   input, carrying the new q8.24 rate and the step count since reload
//   config port (cfg_we / cfg_addr / cfg_wdata): single-cycle writes, only
//   while the block is idle; indexes above five are dropped
// timing
//   one item at a time; in_ready is high only while the sequencer is idle
//   latency is data dependent, and a new item is taken once the sequencer
//   is back in idle: a 28-step square root runs beside the k*dt multiply,
//   then three bit-serial multiplies (sigma*sqrt, *sqrt(dt), *z) follow in
//   series on one multiplier while the drift multiply runs on the other;
//   each multiply ends early once the remaining multiplier bits are zero
// reset and stall
//   synchronous reset clears the config and control registers, rate and index
//   the result sits in an output register; a new item is taken while it
//   waits, and a finished step holds until that register is free
// ----------------------------------------------------------------------------
module cir_short_rate_euler_step_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cir_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cir_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [cir_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cir_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cir_pkg::*;

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_MEAN_LEVEL  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSION   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VOL_COEFF   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_START_RATE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_ROOT   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,    // square root and k*dt
    S_DRIFT,   // kdt*|theta-r| and sigma*sqrt(r)
    S_SCALE,   // times sqrt(dt)
    S_NOISE,   // times |z|
    S_SUM,     // r +/- drift
    S_OUT      // +/- diffusion, clamp, hand to output register
  } state_t;

  state_t state_r;

  // configuration registers
  logic [RATE_W-1:0] mean_level_r;
  logic [RATE_W-1:0] reversion_r;
  logic [RATE_W-1:0] vol_coeff_r;
  logic [RATE_W-1:0] start_rate_r;
  logic [STEP_W-1:0] step_size_r;
  logic [STEP_W-1:0] step_root_r;

  // step state
  logic [RATE_W-1:0]  rate_r;
  logic               started_r;
  logic [IDX_W-1:0]   cnt_r;
  logic               zneg_r;
  logic [NOISE_W-1:0] zmag_r;
  logic [SUM_W-1:0]   sum_r;

  // unit control
  logic start_a_r;
  logic start_b_r;
  logic start_sq_r;
  logic busy_a;
  logic busy_b;
  logic busy_sq;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [ROOT_W-1:0] sq_root;
  mul_req_t          req_a;
  mul_req_t          req_b;

  // output register
  logic out_valid_r;
  out_t out_r;

  // datapath
  logic               in_xfer;
  logic               out_free;
  logic [NOISE_W-1:0] zbits;
  logic [NOISE_W-1:0] zmag_in;
  logic [RATE_W-1:0]  kdt;
  logic               dneg;
  logic [RATE_W-1:0]  dmag;
  logic [DRIFT_W-1:0] drift_mag;
  logic [DIFF_W-1:0]  diff_mag;
  logic [SUM_W-1:0]   drift_ext;
  logic [SUM_W-1:0]   diff_ext;
  logic [SUM_W-1:0]   total;
  logic [RATE_W-1:0]  next_rate;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    zbits   = in_data.noise;
    zmag_in = zbits[NOISE_W-1] ? (~zbits + 1'b1) : zbits;

    // k*dt in q8.24, saturated at the top
    kdt = prod_a[RATE_W+FRAC_W] ? '1 : prod_a[RATE_W+FRAC_W-1:FRAC_W];

    dneg = (rate_r > mean_level_r);
    dmag = dneg ? (rate_r - mean_level_r) : (mean_level_r - rate_r);

    drift_mag = prod_a[FRAC_W+DRIFT_W-1:FRAC_W];
    diff_mag  = prod_b[NOISE_FRAC+DIFF_W-1:NOISE_FRAC];
    drift_ext = {{(SUM_W-DRIFT_W){1'b0}}, drift_mag};
    diff_ext  = {{(SUM_W-DIFF_W){1'b0}}, diff_mag};

    total = zneg_r ? (sum_r - diff_ext) : (sum_r + diff_ext);
    // full truncation at zero, saturation at the top
    if (total[SUM_W-1]) begin
      next_rate = '0;
    end else if (|total[SUM_W-2:RATE_W]) begin
      next_rate = '1;
    end else begin
      next_rate = total[RATE_W-1:0];
    end
  end

  // operand steering: each unit samples its operands in the start cycle
  always_comb begin
    req_a.start = start_a_r;
    if (state_r == S_DRIFT) begin
      req_a.mcand = {{(MCAND_W-RATE_W){1'b0}}, dmag};
      req_a.mplr  = kdt;
    end else begin
      req_a.mcand = {{(MCAND_W-RATE_W){1'b0}}, reversion_r};
      req_a.mplr  = {{(MPLR_W-STEP_W){1'b0}}, step_size_r};
    end

    req_b.start = start_b_r;
    case (state_r)
      S_SCALE: begin
        // a = sigma*sqrt(r), 36 bits
        req_b.mcand = {1'b0, prod_b[FRAC_W+MCAND_W-2:FRAC_W]};
        req_b.mplr  = {{(MPLR_W-STEP_W){1'b0}}, step_root_r};
      end
      S_NOISE: begin
        // b = a*sqrt(dt), 37 bits
        req_b.mcand = prod_b[FRAC_W+MCAND_W-1:FRAC_W];
        req_b.mplr  = {{(MPLR_W-NOISE_W){1'b0}}, zmag_r};
      end
      default: begin
        req_b.mcand = {{(MCAND_W-RATE_W){1'b0}}, vol_coeff_r};
        req_b.mplr  = {{(MPLR_W-ROOT_W){1'b0}}, sq_root};
      end
    endcase
  end

  cir_sermul u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_a),
    .busy  (busy_a),
    .prod  (prod_a)
  );

  cir_sermul u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_b),
    .busy  (busy_b),
    .prod  (prod_b)
  );

  cir_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_sq_r),
    .rad   (rate_r),
    .busy  (busy_sq),
    .root  (sq_root)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_level_r <= '0;
      reversion_r  <= '0;
      vol_coeff_r  <= '0;
      start_rate_r <= '0;
      step_size_r  <= '0;
      step_root_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MEAN_LEVEL: mean_level_r <= cfg_wdata[RATE_W-1:0];
        REG_REVERSION:  reversion_r  <= cfg_wdata[RATE_W-1:0];
        REG_VOL_COEFF:  vol_coeff_r  <= cfg_wdata[RATE_W-1:0];
        REG_START_RATE: start_rate_r <= cfg_wdata[RATE_W-1:0];
        REG_STEP_SIZE:  step_size_r  <= cfg_wdata[STEP_W-1:0];
        REG_STEP_ROOT:  step_root_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_a_r   <= 1'b0;
      start_b_r   <= 1'b0;
      start_sq_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rate_r      <= '0;
      started_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      start_a_r  <= 1'b0;
      start_b_r  <= 1'b0;
      start_sq_r <= 1'b0;
      // result register: loaded at the end of a step, cleared after its transfer
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            zneg_r <= zbits[NOISE_W-1];
            zmag_r <= zmag_in;
            if (in_data.restart || !started_r) begin
              rate_r    <= start_rate_r;
              cnt_r     <= '0;
              started_r <= 1'b1;
            end
            start_a_r  <= 1'b1;
            start_sq_r <= 1'b1;
            state_r    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!busy_a && !busy_sq) begin
            start_a_r <= 1'b1;
            start_b_r <= 1'b1;
            state_r   <= S_DRIFT;
          end
        end
        S_DRIFT: begin
          if (!busy_a && !busy_b) begin
            start_b_r <= 1'b1;
            state_r   <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (!busy_b) begin
            start_b_r <= 1'b1;
            state_r   <= S_NOISE;
          end
        end
        S_NOISE: begin
          if (!busy_b) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r <= dneg ? ({{(SUM_W-RATE_W){1'b0}}, rate_r} - drift_ext)
                        : ({{(SUM_W-RATE_W){1'b0}}, rate_r} + drift_ext);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_r.rate       <= next_rate;
            out_r.step_index <= cnt_r + 1'b1;
            rate_r           <= next_rate;
            cnt_r            <= cnt_r + 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result only appears at the end of a step
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result register loaded outside the output state");

  // arithmetic units are quiet whenever the sequencer is idle
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!busy_a && !busy_b && !busy_sq))
    else $error("arithmetic unit busy while sequencer idle");

  // restart zeroes the step count before stepping
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.restart) |=> (cnt_r == '0))
    else $error("restart did not clear step count");

  // once loaded, the start flag stays set until reset
  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(started_r) |-> started_r)
    else $error("started flag dropped");
`endif

endmodule
